@@ hdl/nmea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_pkg
// shared types, constants and number conversion helpers of the nmea parser
// ----------------------------------------------------------------------------
package nmea_pkg;

	localparam int SENTENCE_MAX  = 128;
	localparam int LAT_FIELD_MAX = 11;
	localparam int LON_FIELD_MAX = 12;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_EOL    = 8'h0d;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_E      = 8'h45;

	localparam logic [29:0] LAT_CAP    = 30'd99999999;
	localparam logic [29:0] LON_CAP    = 30'd999999999;
	localparam logic [29:0] SPEED_CAP  = 30'd999990;
	localparam logic [29:0] DATE_CAP   = 30'd999999;
	localparam logic [29:0] QUAL_CAP   = 30'd9;
	localparam logic [29:0] SATS_CAP   = 30'd99;
	localparam logic [29:0] ALT_POSCAP = 30'd10000000;
	localparam logic [29:0] ALT_NEGCAP = 30'd1000000;

	localparam logic [39:0] ACC_BIG = 40'h80_0000_0000;

	typedef enum logic [1:0] {
		KIND_RMC,
		KIND_GGA,
		KIND_NONE
	} kind_t;

	// running number accumulator of one field
	typedef struct packed {
		logic [39:0] mag;
		logic [3:0]  fd;
		logic        dot;
		logic        stop;
		logic        neg;
	} acc_t;

	function automatic kind_t sentence_type(input logic [39:0] p);
		kind_t k;
		k = KIND_NONE;
		if (p[7:0] == 8'h47 && (p[15:8] == 8'h50 || p[15:8] == 8'h4e)) begin
			if (p[23:16] == 8'h52 && p[31:24] == 8'h4d && p[39:32] == 8'h43)
				k = KIND_RMC;
			else if (p[23:16] == 8'h47 && p[31:24] == 8'h47 && p[39:32] == 8'h41)
				k = KIND_GGA;
		end
		return k;
	endfunction

	function automatic acc_t acc_step(input acc_t a, input logic [7:0] c,
		input logic [3:0] fc, input logic [4:0] limit, input logic [2:0] scale,
		input logic sign_ok);
		acc_t r;
		logic [43:0] m;
		r = a;
		m = {4'd0, a.mag} * 44'd10 + {40'd0, c[3:0]};
		if (({1'b0, fc} + 5'd1) < limit && !a.stop) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (!a.dot || a.fd < {1'b0, scale}) begin
					r.mag = (m > {4'd0, ACC_BIG}) ? ACC_BIG : m[39:0];
					if (a.dot)
						r.fd = a.fd + 4'd1;
				end
			end else if (c == CH_DOT && !a.dot) begin
				r.dot = 1'b1;
			end else if (sign_ok && fc == 4'd0 && (c == CH_MINUS || c == CH_PLUS)) begin
				if (c == CH_MINUS)
					r.neg = 1'b1;
			end else begin
				r.stop = 1'b1;
			end
		end
		return r;
	endfunction

	// scale the accumulated digits to the field's fixed point and saturate
	function automatic logic [29:0] acc_conv(input acc_t a, input logic [2:0] scale,
		input logic [29:0] cap);
		logic [2:0]  sh;
		logic [13:0] p;
		logic [43:0] prod;
		logic [29:0] r;
		sh = (a.fd <= {1'b0, scale}) ? (scale - a.fd[2:0]) : 3'd0;
		case (sh)
			3'd0:    p = 14'd1;
			3'd1:    p = 14'd10;
			3'd2:    p = 14'd100;
			3'd3:    p = 14'd1000;
			default: p = 14'd10000;
		endcase
		prod = {14'd0, a.mag[29:0]} * {30'd0, p};
		if (a.mag > {10'd0, cap})
			r = cap;
		else if (prod > {14'd0, cap})
			r = cap;
		else
			r = prod[29:0];
		return r;
	endfunction

endpackage

@@ hdl/nmea_rmc_gga_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_gga_parser_unit
// nmea gga / rmc sentence parser, one received character per request
// ----------------------------------------------------------------------------
// the end-of-line byte passes the byte register and then the commit stage before
//   m_axis_tvalid rises; either step can wait behind a stalled output
// throughput: one byte per cycle; the byte register, the commit stage and the
//   output register each hold one item, ready falls only when a commit waits
//   behind a stalled output
// reset: arst_n clears parser state and loads the default kept position record
module nmea_rmc_gga_parser_unit
	import nmea_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [19:0] utc_time, [20] fix_valid, [48:21] latitude, [79:49] longitude,
	// [99:80] speed_tenths, [119:100] course_tenths, [139:120] date_ddmmyy,
	// [143:140] fix_quality, [150:144] satellites, [175:151] altitude_dm
	output logic [175:0] m_axis_tdata,
	output logic         m_axis_tuser    // [0] sentence_kind
);

	localparam logic [7:0] CC_LIMIT = 8'(SENTENCE_MAX - 2);
	localparam logic [4:0] LAT_LIM  = 5'(LAT_FIELD_MAX);
	localparam logic [4:0] LON_LIM  = 5'(LON_FIELD_MAX);

	// input byte register
	logic [7:0]  byte_s1;
	logic        vld_s1;
	// commit request waiting for the output register
	logic        cvld_s2;
	kind_t       ckind_s2;

	// parser state
	logic        in_sent_q;
	logic [7:0]  cc_q;
	logic [39:0] prefix_q;
	logic [4:0]  fn_q;
	logic [3:0]  fc_q;
	acc_t        acc_q [8];
	logic [7:0]  tm_q [3];
	logic [2:0]  tabs_q;
	logic        hemi_s_q;
	logic        hemi_e_q;
	logic        status_q;

	// kept position record
	logic [19:0] k_time_q;
	logic        k_fix_q;
	logic [27:0] k_lat_q;
	logic [30:0] k_lon_q;
	logic [19:0] k_speed_q;
	logic [19:0] k_course_q;
	logic [19:0] k_date_q;
	logic [3:0]  k_qual_q;
	logic [6:0]  k_sats_q;
	logic [24:0] k_alt_q;

	logic s2_go, s2_free, proc;

	// the commit stage drains into the output register when it is empty or being read
	assign s2_go         = cvld_s2 && (!m_axis_tvalid || m_axis_tready);
	assign s2_free       = !cvld_s2 || s2_go;
	assign proc          = vld_s1 && s2_free;
	assign s_axis_tready = !vld_s1 || s2_free;

	// ---------------- byte parsing, next state ----------------
	logic        in_sent_n;
	logic [7:0]  cc_n;
	logic [39:0] prefix_n;
	logic [4:0]  fn_n;
	logic [3:0]  fc_n;
	acc_t        acc_n [8];
	logic [7:0]  tm_n [3];
	logic [2:0]  tabs_n;
	logic        hemi_s_n, hemi_e_n, status_n;
	logic        commit;
	kind_t       commit_kind;

	// field routing
	kind_t       fkind;
	logic        acc_en;
	logic [2:0]  sel;
	logic [4:0]  lim;
	logic [2:0]  scl;
	logic        sgn;
	logic        set_st, set_s, set_e;
	logic [1:0]  tp;
	logic [7:0]  c;
	logic        ovf, open;
	logic [7:0]  tdig;

	always_comb begin
		c           = byte_s1;
		ovf         = cc_q >= CC_LIMIT;
		open        = in_sent_q && !ovf;
		in_sent_n   = in_sent_q;
		cc_n        = cc_q;
		prefix_n    = prefix_q;
		fn_n        = fn_q;
		fc_n        = fc_q;
		acc_n       = acc_q;
		tm_n        = tm_q;
		tabs_n      = tabs_q;
		hemi_s_n    = hemi_s_q;
		hemi_e_n    = hemi_e_q;
		status_n    = status_q;
		commit      = 1'b0;
		commit_kind = sentence_type(prefix_q);
		acc_en      = 1'b0;
		sel         = 3'd0;
		lim         = 5'd0;
		scl         = 3'd0;
		sgn         = 1'b0;
		set_st      = 1'b0;
		set_s       = 1'b0;
		set_e       = 1'b0;
		tp          = fc_q[2:1];
		tdig        = tm_q[tp] * 8'd10 + {4'd0, c[3:0]};

		if (ovf) begin
			in_sent_n = 1'b0;
			cc_n      = 8'd0;
		end

		if (c >= 8'd1 && cc_q >= 8'd1 && cc_q <= 8'd5)
			prefix_n = prefix_q | ({32'd0, c} << (8 * (cc_q - 8'd1)));
		fkind = sentence_type(prefix_n);

		// per-kind field map
		case (fkind)
			KIND_RMC: begin
				case (fn_q)
					5'd2: set_st = 1'b1;
					5'd3: begin acc_en = 1'b1; sel = 3'd2; lim = LAT_LIM; scl = 3'd4; end
					5'd4: set_s = 1'b1;
					5'd5: begin acc_en = 1'b1; sel = 3'd4; lim = LON_LIM; scl = 3'd4; end
					5'd6: set_e = 1'b1;
					5'd7: begin acc_en = 1'b1; sel = 3'd5; lim = 5'd6; scl = 3'd1; end
					5'd8: begin acc_en = 1'b1; sel = 3'd6; lim = 5'd6; scl = 3'd1; end
					5'd9: begin acc_en = 1'b1; sel = 3'd7; lim = 5'd7; scl = 3'd0; end
					default: ;
				endcase
			end
			KIND_GGA: begin
				case (fn_q)
					5'd2: begin acc_en = 1'b1; sel = 3'd2; lim = LAT_LIM; scl = 3'd4; end
					5'd3: set_s = 1'b1;
					5'd4: begin acc_en = 1'b1; sel = 3'd4; lim = LON_LIM; scl = 3'd4; end
					5'd5: set_e = 1'b1;
					5'd6: begin acc_en = 1'b1; sel = 3'd1; lim = 5'd2; scl = 3'd0; end
					5'd7: begin acc_en = 1'b1; sel = 3'd5; lim = 5'd3; scl = 3'd0; end
					5'd9: begin
						acc_en = 1'b1; sel = 3'd6; lim = 5'd8; scl = 3'd1; sgn = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (!open) begin
			// hunting for a sentence start
			if (c == CH_DOLLAR) begin
				in_sent_n = 1'b1;
				cc_n      = 8'd1;
				prefix_n  = 40'd0;
				fn_n      = 5'd0;
				fc_n      = 4'd0;
				for (int i = 0; i < 8; i++)
					acc_n[i] = '0;
				for (int i = 0; i < 3; i++)
					tm_n[i] = 8'd0;
				tabs_n    = 3'd0;
				hemi_s_n  = 1'b0;
				hemi_e_n  = 1'b0;
				status_n  = 1'b0;
			end else begin
				prefix_n = prefix_q;
			end
		end else if (c <= CH_EOL) begin
			// end of line, or any byte up to carriage return, closes the sentence
			prefix_n  = prefix_q;
			in_sent_n = 1'b0;
			cc_n      = 8'd0;
			commit    = commit_kind != KIND_NONE;
		end else begin
			if (c == CH_COMMA) begin
				if (fn_q != 5'd31)
					fn_n = fn_q + 5'd1;
				fc_n = 4'd0;
			end else begin
				if (fn_q == 5'd1) begin
					// time digits as three pairs
					if (fc_q < 4'd6 && !tabs_q[tp]) begin
						if (c >= CH_ZERO && c <= CH_NINE)
							tm_n[tp] = tdig;
						else
							tabs_n[tp] = 1'b1;
					end
				end else if (fn_q >= 5'd2) begin
					if (acc_en)
						acc_n[sel] = acc_step(acc_q[sel], c, fc_q, lim, scl, sgn);
					if (fc_q == 4'd0 && set_st && c == CH_A)
						status_n = 1'b1;
					if (fc_q == 4'd0 && set_s && c == CH_S)
						hemi_s_n = 1'b1;
					if (fc_q == 4'd0 && set_e && c == CH_E)
						hemi_e_n = 1'b1;
				end
				if (fc_q != 4'd15)
					fc_n = fc_q + 4'd1;
			end
			cc_n = cc_q + 8'd1;
		end
	end

	// ---------------- commit conversion ----------------
	logic [29:0] lat_m, lon_m, spd_m, crs_m, date_m, qual_m, sats_m, alt_m;
	logic [19:0] time_n;
	logic [23:0] time_w;
	logic [27:0] lat_n;
	logic [30:0] lon_n;
	logic [24:0] alt_n;

	always_comb begin
		lat_m  = acc_conv(acc_q[2], 3'd4, LAT_CAP);
		lon_m  = acc_conv(acc_q[4], 3'd4, LON_CAP);
		spd_m  = acc_conv(acc_q[5], 3'd1, SPEED_CAP);
		crs_m  = acc_conv(acc_q[6], 3'd1, SPEED_CAP);
		date_m = acc_conv(acc_q[7], 3'd0, DATE_CAP);
		qual_m = acc_conv(acc_q[1], 3'd0, QUAL_CAP);
		sats_m = acc_conv(acc_q[5], 3'd0, SATS_CAP);
		// negative altitude saturates at its own, smaller bound
		alt_m  = acc_conv(acc_q[6], 3'd1, acc_q[6].neg ? ALT_NEGCAP : ALT_POSCAP);
		time_w = {16'd0, tm_q[0]} * 24'd10000 + {16'd0, tm_q[1]} * 24'd100
			+ {16'd0, tm_q[2]};
		time_n = time_w[19:0];
		lat_n  = hemi_s_q ? -lat_m[27:0] : lat_m[27:0];
		lon_n  = hemi_e_q ? {1'b0, lon_m} : -{1'b0, lon_m};
		alt_n  = acc_q[6].neg ? -alt_m[24:0] : alt_m[24:0];
	end

	// kept record as it stands after this commit
	logic [19:0] nk_speed, nk_course, nk_date;
	logic        nk_fix;
	logic [3:0]  nk_qual;
	logic [6:0]  nk_sats;
	logic [24:0] nk_alt;

	always_comb begin
		nk_fix    = k_fix_q;
		nk_speed  = k_speed_q;
		nk_course = k_course_q;
		nk_date   = k_date_q;
		nk_qual   = k_qual_q;
		nk_sats   = k_sats_q;
		nk_alt    = k_alt_q;
		case (ckind_s2)
			KIND_RMC: begin
				nk_fix    = status_q;
				nk_speed  = spd_m[19:0];
				nk_course = crs_m[19:0];
				nk_date   = date_m[19:0];
			end
			KIND_GGA: begin
				nk_qual = qual_m[3:0];
				nk_sats = sats_m[6:0];
				nk_alt  = alt_n;
			end
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			byte_s1       <= 8'd0;
			cvld_s2       <= 1'b0;
			ckind_s2      <= KIND_NONE;
			m_axis_tvalid <= 1'b0;
			in_sent_q     <= 1'b0;
			cc_q          <= 8'd0;
			prefix_q      <= 40'd0;
			fn_q          <= 5'd0;
			fc_q          <= 4'd0;
			for (int i = 0; i < 8; i++)
				acc_q[i] <= '0;
			for (int i = 0; i < 3; i++)
				tm_q[i] <= 8'd0;
			tabs_q        <= 3'd0;
			hemi_s_q      <= 1'b0;
			hemi_e_q      <= 1'b0;
			status_q      <= 1'b0;
			k_time_q      <= 20'd0;
			k_fix_q       <= 1'b0;
			k_lat_q       <= 28'sd12345678;
			k_lon_q       <= -31'sd123456789;
			k_speed_q     <= 20'd0;
			k_course_q    <= 20'd0;
			k_date_q      <= 20'd0;
			k_qual_q      <= 4'd0;
			k_sats_q      <= 7'd0;
			k_alt_q       <= 25'd0;
		end else begin
			// byte register
			if (s_axis_tvalid && s_axis_tready) begin
				vld_s1  <= 1'b1;
				byte_s1 <= s_axis_tdata;
			end else if (proc) begin
				vld_s1 <= 1'b0;
			end

			// parser state steps once per processed byte
			if (proc) begin
				in_sent_q <= in_sent_n;
				cc_q      <= cc_n;
				prefix_q  <= prefix_n;
				fn_q      <= fn_n;
				fc_q      <= fc_n;
				acc_q     <= acc_n;
				tm_q      <= tm_n;
				tabs_q    <= tabs_n;
				hemi_s_q  <= hemi_s_n;
				hemi_e_q  <= hemi_e_n;
				status_q  <= status_n;
			end

			// commit stage
			if (proc && commit) begin
				cvld_s2  <= 1'b1;
				ckind_s2 <= commit_kind;
			end else if (s2_go) begin
				cvld_s2 <= 1'b0;
			end

			// kept record and output register
			if (s2_go) begin
				k_time_q      <= time_n;
				k_lat_q       <= lat_n;
				k_lon_q       <= lon_n;
				k_fix_q       <= nk_fix;
				k_speed_q     <= nk_speed;
				k_course_q    <= nk_course;
				k_date_q      <= nk_date;
				k_qual_q      <= nk_qual;
				k_sats_q      <= nk_sats;
				k_alt_q       <= nk_alt;
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// output payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s2_go) begin
			m_axis_tuser <= (ckind_s2 == KIND_GGA);
			m_axis_tdata <= {nk_alt, nk_sats, nk_qual, nk_date, nk_course, nk_speed,
				lon_n, lat_n, nk_fix, time_n};
		end
	end

endmodule
